[sv/e2q_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package e2q_pkg;

    // lane order of the three angles through the rotation row
    localparam int LANES      = 3;
    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;

    // quaternion component order
    localparam int QUAT_N = 4;
    localparam int QI_W   = 0;
    localparam int QI_X   = 1;
    localparam int QI_Y   = 2;
    localparam int QI_Z   = 3;

    localparam int IN_W       = 16;     // Q3.13 angle fields
    localparam int Q_W        = 16;     // Q1.14 quaternion fields
    localparam int Q_ONE      = 16384;  // 1.0 in Q1.14
    localparam int SC_W       = 18;     // sine / cosine in Q.15 with headroom
    localparam int PROD_SHIFT = 31;     // Q.45 triple product down to Q.14
    localparam int TAB_LEN    = 32;     // longest arctangent table

    // round half up of a non-negative constant by s bits
    function automatic longint unsigned rnd_u(longint unsigned v, int s);
        if (s <= 0) begin
            return v;
        end
        return (v + (64'd1 << (s - 1))) >> s;
    endfunction

    // shift-and-subtract quotient for the constant tables
    function automatic longint unsigned udiv_u(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v) begin
            b = b >> 2;
        end
        while (b != 64'd0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // pi/4 in Q.60, two-term arctangent identity
    function automatic longint unsigned pi4_q60();
        longint unsigned one;
        longint unsigned p;
        longint unsigned acc;
        longint unsigned term;
        longint unsigned k;
        longint unsigned a5;
        one = 64'd1 << 60;
        p   = udiv_u(one, 64'd5);
        acc = 64'd0;
        k   = 64'd0;
        while (p != 64'd0) begin
            term = udiv_u(p, 2 * k + 1);
            acc  = k[0] ? acc - term : acc + term;
            p    = udiv_u(p, 64'd25);
            k    = k + 1;
        end
        a5  = acc;
        p   = udiv_u(one, 64'd239);
        acc = 64'd0;
        k   = 64'd0;
        while (p != 64'd0) begin
            term = udiv_u(p, 2 * k + 1);
            acc  = k[0] ? acc - term : acc + term;
            p    = udiv_u(p, 64'd57121);
            k    = k + 1;
        end
        return 4 * a5 - acc;
    endfunction

    // atan(2^-i) in Q.60
    function automatic longint unsigned atan_q60(int i);
        longint unsigned p;
        longint unsigned acc;
        longint unsigned term;
        longint unsigned k;
        if (i == 0) begin
            return pi4_q60();
        end
        p   = 64'd1 << (60 - i);
        acc = 64'd0;
        k   = 64'd0;
        while (p != 64'd0) begin
            term = udiv_u(p, 2 * k + 1);
            acc  = k[0] ? acc - term : acc + term;
            p    = p >> (2 * i);
            k    = k + 1;
        end
        return acc;
    endfunction

    // square of the inverse rotation gain over the given number of steps, Q.60
    function automatic longint unsigned gain2_q60(int stages);
        longint unsigned g;
        g = 64'd1 << 60;
        for (int i = 0; i < stages && i < TAB_LEN; i++) begin
            if (i == 0) begin
                g = g >> 1;
            end else begin
                g = g - udiv_u(g, (64'd1 << (2 * i)) + 1);
            end
        end
        return g;
    endfunction

endpackage

`default_nettype wire

[sv/e2q_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface e2q_angle_if;
    logic                           valid;
    logic                           ready;
    logic signed [e2q_pkg::IN_W-1:0] roll_angle;
    logic signed [e2q_pkg::IN_W-1:0] pitch_angle;
    logic signed [e2q_pkg::IN_W-1:0] yaw_angle;

    modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                    input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                    output ready);
endinterface

interface e2q_quat_if;
    logic                          valid;
    logic                          ready;
    logic signed [e2q_pkg::Q_W-1:0] quat_w;
    logic signed [e2q_pkg::Q_W-1:0] quat_x;
    logic signed [e2q_pkg::Q_W-1:0] quat_y;
    logic signed [e2q_pkg::Q_W-1:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

`default_nettype wire

[sv/e2q_prep.sv]
`timescale 1ns / 1ps
`default_nettype none

module e2q_prep #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_en,
    input  logic                                                i_valid,
    input  logic [e2q_pkg::LANES-1:0][e2q_pkg::IN_W-1:0]        i_angle,
    output logic                                                o_valid,
    output logic [e2q_pkg::LANES-1:0][ANGLE_BITS:0]             o_z,
    output logic [e2q_pkg::LANES-1:0]                           o_neg
);

    localparam int F  = ANGLE_BITS - 2;
    localparam int ZW = ANGLE_BITS + 1;
    localparam logic signed [ZW-1:0] HPI  = ZW'(e2q_pkg::rnd_u(2 * e2q_pkg::pi4_q60(), 60 - F));
    localparam logic signed [ZW-1:0] PI_Z = ZW'(e2q_pkg::rnd_u(4 * e2q_pkg::pi4_q60(), 60 - F));

    logic signed [ZW-1:0] w_z   [e2q_pkg::LANES];
    logic signed [ZW-1:0] n_z   [e2q_pkg::LANES];
    logic                 n_neg [e2q_pkg::LANES];
    logic                 r_valid;
    logic [e2q_pkg::LANES-1:0][ZW-1:0] r_z;
    logic [e2q_pkg::LANES-1:0]         r_neg;

    // the Q3.13 angle is already the half angle in Q.14; bring it to F fraction bits
    for (genvar l = 0; l < e2q_pkg::LANES; l++) begin : g_lane
        if (F >= 14) begin : g_up
            logic signed [ZW-1:0] w_ext;
            assign w_ext  = ZW'($signed(i_angle[l]));
            assign w_z[l] = w_ext <<< (F - 14);
        end else begin : g_down
            logic signed [e2q_pkg::IN_W:0] w_sum;
            assign w_sum  = (e2q_pkg::IN_W + 1)'($signed(i_angle[l]))
                          + (e2q_pkg::IN_W + 1)'(1 << (13 - F));
            assign w_z[l] = ZW'(w_sum >>> (14 - F));
        end
    end

    // fold into [-pi/2, pi/2]; the cosine sign flips when folded
    always_comb begin
        for (int l = 0; l < e2q_pkg::LANES; l++) begin
            if (w_z[l] > HPI) begin
                n_z[l]   = PI_Z - w_z[l];
                n_neg[l] = 1'b1;
            end else if (w_z[l] < -HPI) begin
                n_z[l]   = -PI_Z - w_z[l];
                n_neg[l] = 1'b1;
            end else begin
                n_z[l]   = w_z[l];
                n_neg[l] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < e2q_pkg::LANES; l++) begin
                r_z[l]   <= n_z[l];
                r_neg[l] <= n_neg[l];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_z     = r_z;
    assign o_neg   = r_neg;

endmodule

`default_nettype wire

[sv/e2q_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module e2q_cordic_cell #(
    parameter int ANGLE_BITS = 16,
    parameter int STAGE      = 0
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  logic [e2q_pkg::LANES-1:0][ANGLE_BITS-1:0]   i_x,
    input  logic [e2q_pkg::LANES-1:0][ANGLE_BITS-1:0]   i_y,
    input  logic [e2q_pkg::LANES-1:0][ANGLE_BITS:0]     i_z,
    input  logic [e2q_pkg::LANES-1:0]                   i_neg,
    output logic                                        o_valid,
    output logic [e2q_pkg::LANES-1:0][ANGLE_BITS-1:0]   o_x,
    output logic [e2q_pkg::LANES-1:0][ANGLE_BITS-1:0]   o_y,
    output logic [e2q_pkg::LANES-1:0][ANGLE_BITS:0]     o_z,
    output logic [e2q_pkg::LANES-1:0]                   o_neg
);

    localparam int F  = ANGLE_BITS - 2;
    localparam int XW = ANGLE_BITS;
    localparam int ZW = ANGLE_BITS + 1;
    localparam logic signed [ZW-1:0] ATAN_T =
        ZW'(e2q_pkg::rnd_u(e2q_pkg::atan_q60(STAGE), 60 - F));

    logic signed [XW-1:0] n_x [e2q_pkg::LANES];
    logic signed [XW-1:0] n_y [e2q_pkg::LANES];
    logic signed [ZW-1:0] n_z [e2q_pkg::LANES];
    logic                 r_valid;
    logic [e2q_pkg::LANES-1:0][XW-1:0] r_x;
    logic [e2q_pkg::LANES-1:0][XW-1:0] r_y;
    logic [e2q_pkg::LANES-1:0][ZW-1:0] r_z;
    logic [e2q_pkg::LANES-1:0]         r_neg;

    // one rotation step, direction from the sign of the residual angle
    always_comb begin
        for (int l = 0; l < e2q_pkg::LANES; l++) begin
            if (!i_z[l][ZW-1]) begin
                n_x[l] = $signed(i_x[l]) - ($signed(i_y[l]) >>> STAGE);
                n_y[l] = $signed(i_y[l]) + ($signed(i_x[l]) >>> STAGE);
                n_z[l] = $signed(i_z[l]) - ATAN_T;
            end else begin
                n_x[l] = $signed(i_x[l]) + ($signed(i_y[l]) >>> STAGE);
                n_y[l] = $signed(i_y[l]) - ($signed(i_x[l]) >>> STAGE);
                n_z[l] = $signed(i_z[l]) + ATAN_T;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < e2q_pkg::LANES; l++) begin
                r_x[l] <= n_x[l];
                r_y[l] <= n_y[l];
                r_z[l] <= n_z[l];
            end
            r_neg <= i_neg;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_neg   = r_neg;

endmodule

`default_nettype wire

[sv/e2q_combine.sv]
`timescale 1ns / 1ps
`default_nettype none

module e2q_combine #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_en,
    input  logic                                            i_valid,
    input  logic [e2q_pkg::LANES-1:0][ANGLE_BITS-1:0]       i_x,
    input  logic [e2q_pkg::LANES-1:0][ANGLE_BITS-1:0]       i_y,
    input  logic [e2q_pkg::LANES-1:0]                       i_neg,
    output logic                                            o_valid,
    output logic [e2q_pkg::QUAT_N-1:0][e2q_pkg::Q_W-1:0]    o_quat
);

    localparam int F      = ANGLE_BITS - 2;
    localparam int CW     = ANGLE_BITS + 1;
    localparam int SW     = e2q_pkg::SC_W;
    localparam int PW     = 2 * SW;
    localparam int TW     = 3 * SW;
    localparam int SUMW   = TW + 1;
    localparam int NSTAGE = 5;
    localparam logic signed [SUMW-1:0] RND_HALF = SUMW'(1) << (e2q_pkg::PROD_SHIFT - 1);
    localparam logic signed [SUMW-1:0] SAT_HI   = SUMW'(e2q_pkg::Q_ONE);
    localparam logic signed [SUMW-1:0] SAT_LO   = -SAT_HI;

    localparam int R = e2q_pkg::LANE_ROLL;
    localparam int P = e2q_pkg::LANE_PITCH;
    localparam int Y = e2q_pkg::LANE_YAW;

    logic [NSTAGE-1:0]    r_valid;
    logic signed [CW-1:0] w_cv [e2q_pkg::LANES];
    logic signed [SW-1:0] n_c  [e2q_pkg::LANES];
    logic signed [SW-1:0] n_s  [e2q_pkg::LANES];
    logic signed [SW-1:0] r_c  [e2q_pkg::LANES];
    logic signed [SW-1:0] r_s  [e2q_pkg::LANES];
    logic signed [PW-1:0] r_cc, r_ss, r_sc, r_cs;
    logic signed [SW-1:0] r_cy, r_sy;
    logic signed [TW-1:0] r_t [8];
    logic signed [SUMW-1:0] r_sum [e2q_pkg::QUAT_N];
    logic signed [SUMW-1:0] w_rnd [e2q_pkg::QUAT_N];
    logic [e2q_pkg::QUAT_N-1:0][e2q_pkg::Q_W-1:0] n_q;
    logic [e2q_pkg::QUAT_N-1:0][e2q_pkg::Q_W-1:0] r_q;

    // cosine sign from the fold, then down (or up) to Q.15
    for (genvar l = 0; l < e2q_pkg::LANES; l++) begin : g_lane
        logic signed [CW-1:0] w_xe;
        logic signed [CW-1:0] w_ye;
        assign w_xe    = CW'($signed(i_x[l]));
        assign w_ye    = CW'($signed(i_y[l]));
        assign w_cv[l] = i_neg[l] ? -w_xe : w_xe;
        if (F > 15) begin : g_rnd
            localparam logic signed [CW-1:0] HALF = CW'(1) << (F - 16);
            assign n_c[l] = SW'((w_cv[l] + HALF) >>> (F - 15));
            assign n_s[l] = SW'((w_ye + HALF) >>> (F - 15));
        end else if (F == 15) begin : g_same
            assign n_c[l] = SW'(w_cv[l]);
            assign n_s[l] = SW'(w_ye);
        end else begin : g_up
            logic signed [SW-1:0] w_ce;
            logic signed [SW-1:0] w_se;
            assign w_ce   = SW'(w_cv[l]);
            assign w_se   = SW'(w_ye);
            assign n_c[l] = w_ce <<< (15 - F);
            assign n_s[l] = w_se <<< (15 - F);
        end
    end

    // round half up by 31 bits and clamp to +-1.0
    always_comb begin
        for (int q = 0; q < e2q_pkg::QUAT_N; q++) begin
            w_rnd[q] = (r_sum[q] + RND_HALF) >>> e2q_pkg::PROD_SHIFT;
            if (w_rnd[q] > SAT_HI) begin
                n_q[q] = e2q_pkg::Q_W'(SAT_HI);
            end else if (w_rnd[q] < SAT_LO) begin
                n_q[q] = e2q_pkg::Q_W'(SAT_LO);
            end else begin
                n_q[q] = e2q_pkg::Q_W'(w_rnd[q]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NSTAGE-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // sine / cosine
            for (int l = 0; l < e2q_pkg::LANES; l++) begin
                r_c[l] <= n_c[l];
                r_s[l] <= n_s[l];
            end
            // roll-pitch pairs
            r_cc <= r_c[R] * r_c[P];
            r_ss <= r_s[R] * r_s[P];
            r_sc <= r_s[R] * r_c[P];
            r_cs <= r_c[R] * r_s[P];
            r_cy <= r_c[Y];
            r_sy <= r_s[Y];
            // triple products in Q.45
            r_t[0] <= r_cc * r_cy;
            r_t[1] <= r_ss * r_sy;
            r_t[2] <= r_sc * r_cy;
            r_t[3] <= r_cs * r_sy;
            r_t[4] <= r_cs * r_cy;
            r_t[5] <= r_sc * r_sy;
            r_t[6] <= r_cc * r_sy;
            r_t[7] <= r_ss * r_cy;
            // zyx combination
            r_sum[e2q_pkg::QI_W] <= SUMW'(r_t[0]) + SUMW'(r_t[1]);
            r_sum[e2q_pkg::QI_X] <= SUMW'(r_t[2]) - SUMW'(r_t[3]);
            r_sum[e2q_pkg::QI_Y] <= SUMW'(r_t[4]) + SUMW'(r_t[5]);
            r_sum[e2q_pkg::QI_Z] <= SUMW'(r_t[6]) - SUMW'(r_t[7]);
            r_q <= n_q;
        end
    end

    assign o_valid = r_valid[NSTAGE-1];
    assign o_quat  = r_q;

endmodule

`default_nettype wire

[sv/euler_to_quaternion.sv]
// Euler (ZYX, roll-pitch-yaw) to unit quaternion converter. Each input beat carries roll,
// pitch and yaw as signed Q3.13 radians; each output beat carries w, x, y, z as signed
// Q1.14, rounded half up and clamped to +-1.0. Any 16-bit angle pattern is legal: half
// angles beyond +-pi/2 are folded with the cosine sign flipped. The half-angle sine and
// cosine come from a row of CORDIC_STAGES rotation cells, one step per cell, working on
// all three angles side by side; a five-stage tail squares up to Q.15, forms the pair and
// triple products and rounds. The block takes one beat every clock cycle while ready is
// high; on its way to output valid an input beat passes one angle prep stage, the cell
// row, five product stages and one output register. The output register has a one-entry
// skid buffer behind it, so input keeps flowing while a result waits; ready drops only
// once the skid entry is occupied. No state is kept between beats and nothing needs
// configuring. ANGLE_BITS sets the CORDIC datapath width (ANGLE_BITS-2 fraction bits).
`timescale 1ns / 1ps
`default_nettype none

module euler_to_quaternion #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    e2q_angle_if.sink     i_angle,
    e2q_quat_if.source    o_quat
);

    localparam int F  = ANGLE_BITS - 2;
    localparam int XW = ANGLE_BITS;
    localparam int ZW = ANGLE_BITS + 1;
    localparam int L  = e2q_pkg::LANES;
    localparam int QN = e2q_pkg::QUAT_N;
    localparam int QW = e2q_pkg::Q_W;

    // start vector is the inverse rotation gain, so the row ends at unit length
    localparam logic [XW-1:0] X0 =
        XW'(e2q_pkg::rnd_u(e2q_pkg::isqrt64(e2q_pkg::gain2_q60(CORDIC_STAGES)), 30 - F));
    localparam logic signed [QW-1:0] Q_MAX = QW'(e2q_pkg::Q_ONE);
    localparam logic signed [QW-1:0] Q_MIN = -Q_MAX;

    // pipeline advance: everything moves unless the skid entry is full
    logic w_adv;

    // packed angles in lane order
    logic [L-1:0][e2q_pkg::IN_W-1:0] w_angle;

    // cell row links, index k feeds cell k
    logic                  w_valid [CORDIC_STAGES+1];
    logic [L-1:0][XW-1:0]  w_x     [CORDIC_STAGES+1];
    logic [L-1:0][XW-1:0]  w_y     [CORDIC_STAGES+1];
    logic [L-1:0][ZW-1:0]  w_z     [CORDIC_STAGES+1];
    logic [L-1:0]          w_neg   [CORDIC_STAGES+1];

    logic                     w_cmb_valid;
    logic [QN-1:0][QW-1:0]    w_cmb_q;

    // output register and skid entry
    logic                     r_out_valid;
    logic                     r_skid_valid;
    logic [QN-1:0][QW-1:0]    r_out_q;
    logic [QN-1:0][QW-1:0]    r_skid_q;

    assign w_adv         = !r_skid_valid;
    assign i_angle.ready = w_adv;

    assign w_angle[e2q_pkg::LANE_ROLL]  = i_angle.roll_angle;
    assign w_angle[e2q_pkg::LANE_PITCH] = i_angle.pitch_angle;
    assign w_angle[e2q_pkg::LANE_YAW]   = i_angle.yaw_angle;

    // half-angle scaling and fold
    e2q_prep #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_angle.valid),
        .i_angle (w_angle),
        .o_valid (w_valid[0]),
        .o_z     (w_z[0]),
        .o_neg   (w_neg[0])
    );

    assign w_x[0] = {L{X0}};
    assign w_y[0] = '0;

    // rotation row, one micro-rotation per cell
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        e2q_cordic_cell #(
            .ANGLE_BITS (ANGLE_BITS),
            .STAGE      (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .i_neg   (w_neg[k]),
            .o_valid (w_valid[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1]),
            .o_neg   (w_neg[k+1])
        );
    end

    // products, rounding, clamp; residual angle of the last cell is dropped
    e2q_combine #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_valid[CORDIC_STAGES]),
        .i_x     (w_x[CORDIC_STAGES]),
        .i_y     (w_y[CORDIC_STAGES]),
        .i_neg   (w_neg[CORDIC_STAGES]),
        .o_valid (w_cmb_valid),
        .o_quat  (w_cmb_q)
    );

    // output register with skid: a beat arriving while the output stalls parks in skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !o_quat.ready) begin
            if (w_adv && w_cmb_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= w_adv && w_cmb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !o_quat.ready) begin
            if (w_adv && w_cmb_valid) begin
                r_skid_q <= w_cmb_q;
            end
        end else if (r_skid_valid) begin
            r_out_q <= r_skid_q;
        end else if (w_adv && w_cmb_valid) begin
            r_out_q <= w_cmb_q;
        end
    end

    assign o_quat.valid  = r_out_valid;
    assign o_quat.quat_w = r_out_q[e2q_pkg::QI_W];
    assign o_quat.quat_x = r_out_q[e2q_pkg::QI_X];
    assign o_quat.quat_y = r_out_q[e2q_pkg::QI_Y];
    assign o_quat.quat_z = r_out_q[e2q_pkg::QI_Z];

    // skid entry is only ever filled behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry occupied with empty output register");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_quat.ready))
        else $error("skid entry filled while output was not stalled");

    // a stalled pipeline must not lose or create a beat at its tail
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_cmb_valid))
        else $error("pipeline tail moved while stalled");

    // clamp keeps every component within +-1.0
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |->
            ($signed(o_quat.quat_w) <= Q_MAX) && ($signed(o_quat.quat_w) >= Q_MIN) &&
            ($signed(o_quat.quat_x) <= Q_MAX) && ($signed(o_quat.quat_x) >= Q_MIN) &&
            ($signed(o_quat.quat_y) <= Q_MAX) && ($signed(o_quat.quat_y) >= Q_MIN) &&
            ($signed(o_quat.quat_z) <= Q_MAX) && ($signed(o_quat.quat_z) >= Q_MIN))
        else $error("quaternion component outside unit range");

endmodule

`default_nettype wire
